FILE: rtl/lcdws_pkg.sv
// Shared types and constants for the character LCD write sequencer.
// No dependencies; used by every module in rtl/.
package lcdws_pkg;

	// Operation codes of an input item
	typedef enum logic [1:0] {
		CMD_INSTR = 2'd0,
		CMD_DATA  = 2'd1,
		CMD_PRINT = 2'd2,
		CMD_INIT  = 2'd3
	} cmd_t;

	// Front sequencer states
	typedef enum logic [1:0] {
		FS_IDLE = 2'd0,
		FS_MUL  = 2'd1,
		FS_DIV  = 2'd2,
		FS_EMIT = 2'd3
	} front_state_t;

	// One byte queued for the bus side
	typedef struct packed {
		logic       rs;
		logic [7:0] data;
		logic [2:0] disp;
		logic       nib;
		logic       last;
	} byte_entry_t;

	// Register indexes of the configuration port
	localparam logic REG_FOUR_BIT_MASK = 1'b0;

	// Byte queue geometry
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = 2;

	// Divide by ten: q = (v * RECIP) >> SHIFT, exact for all 32-bit v
	localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
	localparam int unsigned DIV10_SHIFT = 35;

	localparam logic [7:0] ASCII_ZERO = 8'h30;

	// Init sequence lengths in bytes
	localparam logic [3:0] INIT_LEN_NIB  = 4'd6;
	localparam logic [3:0] INIT_LEN_BYTE = 4'd4;

	// Byte idx of the power-on sequence for a 4-bit or 8-bit bus
	function automatic logic [7:0] init_byte(input logic nib, input logic [3:0] idx);
		logic [7:0] b;
		b = 8'h00;
		if (nib) begin
			case (idx)
				4'd0: b = 8'h33;
				4'd1: b = 8'h32;
				4'd2: b = 8'h28;
				4'd3: b = 8'h0F;
				4'd4: b = 8'h01;
				4'd5: b = 8'h06;
				default: b = 8'h00;
			endcase
		end else begin
			case (idx)
				4'd0: b = 8'h38;
				4'd1: b = 8'h0F;
				4'd2: b = 8'h01;
				4'd3: b = 8'h06;
				default: b = 8'h00;
			endcase
		end
		return b;
	endfunction

endpackage

FILE: rtl/lcdws_front.sv
// Front end: accepts operations, converts numbers to decimal, queues bytes.
// Depends on lcdws_pkg.
module lcdws_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [1:0]                command,
	input  logic [31:0]               value,
	input  logic [2:0]                lcd_index,
	input  logic                      disp_ok,
	input  logic                      nib_mode,
	output logic                      busy,
	output logic                      push,
	output lcdws_pkg::byte_entry_t    push_data,
	input  logic                      full
);

	lcdws_pkg::front_state_t state_q, state_next;
	lcdws_pkg::cmd_t         cmd_q;
	logic [31:0]             v_q;
	logic [63:0]             prod_q;
	logic [2:0]              disp_q;
	logic                    nib_q;
	logic [3:0]              idx_q;
	logic [3:0]              total_q;
	logic [3:0]              dig_q [10];

	logic                    accept;
	logic [28:0]             quot;
	logic [32:0]             quot_x10;
	logic [31:0]             rem_full;
	logic                    last_byte;
	logic [7:0]              byte_sel;

	assign accept   = start && (state_q == lcdws_pkg::FS_IDLE);
	assign busy     = (state_q != lcdws_pkg::FS_IDLE);

	// Quotient and remainder of the registered product
	assign quot     = prod_q[63:lcdws_pkg::DIV10_SHIFT];
	assign quot_x10 = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
	assign rem_full = v_q - quot_x10[31:0];

	assign last_byte = (idx_q == (total_q - 4'd1));

	// Next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			lcdws_pkg::FS_IDLE: begin
				if (start && disp_ok) begin
					if (lcdws_pkg::cmd_t'(command) == lcdws_pkg::CMD_PRINT)
						state_next = lcdws_pkg::FS_MUL;
					else
						state_next = lcdws_pkg::FS_EMIT;
				end
			end
			lcdws_pkg::FS_MUL:  state_next = lcdws_pkg::FS_DIV;
			lcdws_pkg::FS_DIV: begin
				if (quot == 29'd0)
					state_next = lcdws_pkg::FS_EMIT;
				else
					state_next = lcdws_pkg::FS_MUL;
			end
			lcdws_pkg::FS_EMIT: begin
				if (!full && last_byte)
					state_next = lcdws_pkg::FS_IDLE;
			end
			default: state_next = lcdws_pkg::FS_IDLE;
		endcase
	end

	// Byte for the current position
	always_comb begin
		case (cmd_q)
			lcdws_pkg::CMD_INSTR: byte_sel = v_q[7:0];
			lcdws_pkg::CMD_DATA:  byte_sel = v_q[7:0];
			lcdws_pkg::CMD_PRINT: byte_sel = lcdws_pkg::ASCII_ZERO | {4'h0, dig_q[0]};
			lcdws_pkg::CMD_INIT:  byte_sel = lcdws_pkg::init_byte(nib_q, idx_q);
			default:              byte_sel = v_q[7:0];
		endcase
	end

	// Queue write
	always_comb begin
		push           = (state_q == lcdws_pkg::FS_EMIT) && !full;
		push_data.rs   = (cmd_q == lcdws_pkg::CMD_DATA) || (cmd_q == lcdws_pkg::CMD_PRINT);
		push_data.data = byte_sel;
		push_data.disp = disp_q;
		push_data.nib  = nib_q;
		push_data.last = last_byte;
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcdws_pkg::FS_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= lcdws_pkg::cmd_t'(command);
			v_q     <= value;
			disp_q  <= lcd_index;
			nib_q   <= nib_mode;
			idx_q   <= 4'd0;
			case (lcdws_pkg::cmd_t'(command))
				lcdws_pkg::CMD_INIT:
					total_q <= nib_mode ? lcdws_pkg::INIT_LEN_NIB : lcdws_pkg::INIT_LEN_BYTE;
				lcdws_pkg::CMD_PRINT: total_q <= 4'd0;
				default:              total_q <= 4'd1;
			endcase
		end
		if (state_q == lcdws_pkg::FS_MUL) begin
			prod_q <= v_q * lcdws_pkg::DIV10_RECIP;
		end
		// One digit per pass; newest digit goes on top of the stack
		if (state_q == lcdws_pkg::FS_DIV) begin
			dig_q[0] <= rem_full[3:0];
			for (int i = 1; i < 10; i++) dig_q[i] <= dig_q[i-1];
			v_q     <= {3'b000, quot};
			total_q <= total_q + 4'd1;
		end
		// Digits leave from the top of the stack, most significant first
		if (push) begin
			idx_q <= idx_q + 4'd1;
			for (int i = 0; i < 9; i++) dig_q[i] <= dig_q[i+1];
		end
	end

endmodule

FILE: rtl/lcdws_fifo.sv
// Short byte queue between the front end and the bus sequencer.
// Depends on lcdws_pkg.
module lcdws_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  lcdws_pkg::byte_entry_t push_data,
	output logic                   full,
	input  logic                   pop,
	output lcdws_pkg::byte_entry_t head,
	output logic                   empty
);

	lcdws_pkg::byte_entry_t          mem_q [lcdws_pkg::FIFO_DEPTH];
	logic [lcdws_pkg::FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [lcdws_pkg::FIFO_AW:0]     count_q;

	assign full  = (count_q == (lcdws_pkg::FIFO_AW+1)'(lcdws_pkg::FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("byte queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("byte queue underflow");
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(empty || full) |-> (wr_ptr_q == rd_ptr_q)) else $error("queue pointers out of step");

endmodule

FILE: rtl/lcdws_back.sv
// Bus sequencer: turns queued bytes into enable strobes, split into nibbles on 4-bit buses.
// Depends on lcdws_pkg.
module lcdws_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lcdws_pkg::byte_entry_t head,
	input  logic                   empty,
	output logic                   pop,
	output logic                   strobe,
	output logic                   reg_select,
	output logic [7:0]             bus_value,
	output logic [2:0]             display_number,
	output logic                   last_strobe
);

	logic       phase_q;
	logic       strobe_q, rs_q, last_q;
	logic [7:0] bus_q;
	logic [2:0] disp_q;
	logic       fire;

	// A byte leaves after one strobe, or after the low nibble on a 4-bit bus
	assign fire = !empty;
	assign pop  = fire && (!head.nib || phase_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= 1'b0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= fire;
			last_q   <= pop && head.last;
			if (fire && head.nib) phase_q <= !phase_q;
		end
	end

	// Strobe payload
	always_ff @(posedge clk) begin
		if (fire) begin
			rs_q   <= head.rs;
			disp_q <= head.disp;
			if (!head.nib)    bus_q <= head.data;
			else if (phase_q) bus_q <= {head.data[3:0], 4'h0};
			else              bus_q <= {head.data[7:4], 4'h0};
		end
	end

	assign strobe         = strobe_q;
	assign reg_select     = rs_q;
	assign bus_value      = bus_q;
	assign display_number = disp_q;
	assign last_strobe    = last_q;

	a_last_has_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last_q |-> strobe_q) else $error("last flag without strobe");
	a_low_nibble_follows: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (!empty && head.nib)) else $error("low nibble lost");
	a_nibble_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(phase_q) |-> strobe_q && $past(pop)) else $error("nibble pair broken");

endmodule

FILE: rtl/char_lcd_write_sequencer.sv
// Character LCD write sequencer, top level: config register, front end, byte queue, bus side.
// Depends on lcdws_pkg, lcdws_front, lcdws_fifo, lcdws_back.
//
// Usage: drive command/value/lcd_index with start high; the item is taken at an edge
// where start is high and busy is low. Each strobe result appears on reg_select,
// bus_value, display_number and last_strobe for exactly one cycle with strobe high;
// last_strobe marks the final transfer of the item. An index at or above DISPLAY_COUNT
// gives no strobes and busy stays low.
// Flow: the accepting edge registers a byte or init item and moves the front end to its
// emit state; each byte is then written into the queue, and the bus side registers its
// strobe from the queue head. A print first runs a multiply and a remainder step per
// decimal digit, and bytes still queued from earlier items come out ahead.
// Throughput: the front end is busy while it queues each byte, and when printing also
// through the digit steps (one multiply by the reciprocal of ten, one remainder step).
// The bus side gives one strobe per cycle while the queue holds bytes (two per byte on
// a 4-bit bus, up to 20 per item); on a 4-bit bus the four-entry queue fills and the front
// end waits on it. The queue lets the front end take the next item while strobes drain.
// four_bit_mask sits at APB address 0; write it only while no strobes are pending.
// Reset clears the mask, the queue and both sequencers. The receiver cannot stall.
module char_lcd_write_sequencer #(
	parameter int unsigned DISPLAY_COUNT = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// operation channel
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [31:0] value,
	input  logic [2:0]  lcd_index,
	// strobe channel
	output logic        strobe,
	output logic        reg_select,
	output logic [7:0]  bus_value,
	output logic [2:0]  display_number,
	output logic        last_strobe,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0]             mask_q;
	logic                   cfg_wr;
	logic                   disp_ok;
	logic                   push, full, pop, empty;
	lcdws_pkg::byte_entry_t push_data, head;

	// Configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == lcdws_pkg::REG_FOUR_BIT_MASK) ? {24'h0, mask_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= 8'h00;
		end else if (cfg_wr && (paddr[2] == lcdws_pkg::REG_FOUR_BIT_MASK)) begin
			mask_q <= pwdata[7:0];
		end
	end

	assign disp_ok = ({1'b0, lcd_index} < 4'(DISPLAY_COUNT));

	lcdws_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.command   (command),
		.value     (value),
		.lcd_index (lcd_index),
		.disp_ok   (disp_ok),
		.nib_mode  (mask_q[lcd_index]),
		.busy      (busy),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	lcdws_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	lcdws_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.empty          (empty),
		.pop            (pop),
		.strobe         (strobe),
		.reg_select     (reg_select),
		.bus_value      (bus_value),
		.display_number (display_number),
		.last_strobe    (last_strobe)
	);

endmodule
